// ===== rtl/sio_cfg_pkg.sv =====
// Shared constants and decode helpers for the super I/O configuration port unit.
`default_nettype none

package sio_cfg_pkg;

    localparam int NUM_REGS = 16;
    localparam int IDX_W    = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

    localparam logic [7:0] UNLOCK_KEY = 8'h55;
    localparam logic [7:0] LOCK_KEY   = 8'hAA;

    localparam logic [1:0] UNLOCK_IN_CFG = 2'd2;

    localparam logic [7:0] REG_COM34   = 8'd1;
    localparam logic [7:0] REG_UART    = 8'd2;
    localparam logic [7:0] REG_UARTAUX = 8'd4;

    localparam logic       CMD_READ  = 1'b0;
    localparam logic       CMD_WRITE = 1'b1;
    localparam logic       PORT_INDEX = 1'b0;
    localparam logic       PORT_DATA  = 1'b1;

    typedef struct packed {
        logic       enable;
        logic [9:0] base;
        logic [2:0] irq;
    } t_uart_cfg;

    function automatic logic [7:0] reg_reset_value(input int unsigned idx);
        logic [7:0] v;
        v = 8'h00;
        case (idx)
            0:       v = 8'h3B;
            1:       v = 8'h9F;
            2:       v = 8'hDC;
            3:       v = 8'h78;
            6:       v = 8'hFF;
            13:      v = 8'h65;
            14:      v = 8'h02;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    // Mode is a three-bit field of the UART register (bits 2..0 or 6..4); com34 is bits 6..5 of register 1.
    function automatic t_uart_cfg decode_uart(input logic [2:0] mode, input logic [1:0] com34);
        t_uart_cfg  c;
        logic [9:0] com3;
        logic [9:0] com4;
        case (com34)
            2'd0:    begin com3 = 10'h338; com4 = 10'h238; end
            2'd1:    begin com3 = 10'h3E8; com4 = 10'h2E8; end
            2'd2:    begin com3 = 10'h3E8; com4 = 10'h2E0; end
            default: begin com3 = 10'h220; com4 = 10'h228; end
        endcase
        c.enable = mode[2];
        case (mode[1:0])
            2'd0:    begin c.base = 10'h3F8; c.irq = 3'd4; end
            2'd1:    begin c.base = 10'h2F8; c.irq = 3'd3; end
            2'd2:    begin c.base = com3;    c.irq = 3'd4; end
            default: begin c.base = com4;    c.irq = 3'd3; end
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/superio_config_port_unit.sv =====
// Top level of the super I/O configuration port unit: register file, unlock logic, UART decode.
`default_nettype none

// One bus access is taken per cycle while o_in_stall is low, and its result appears in the
// output register on the next cycle. The single output register is why the input stalls:
// while a result waits under a stall, the input side stalls too. Two index-port writes of
// 0x55 enter configuration mode, a write of 0xAA to the index port leaves it, and data-port
// accesses in the mode reach the sixteen configuration registers. Every result carries the
// decode of both serial ports as it stands after the access, plus reapply pulses for ports
// whose setup changed.
module superio_config_port_unit (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic       i_command,
    input  wire logic       i_port_offset,
    input  wire logic [7:0] i_write_data,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic [7:0]      o_read_data,
    output logic            o_read_handled,
    output logic            o_forward_access,
    output logic            o_uart0_enable,
    output logic [9:0]      o_uart0_base,
    output logic [2:0]      o_uart0_irq,
    output logic            o_uart0_reapply,
    output logic            o_uart1_enable,
    output logic [9:0]      o_uart1_base,
    output logic [2:0]      o_uart1_irq,
    output logic            o_uart1_reapply
);
    import sio_cfg_pkg::*;

    logic [1:0] r_unlock, n_unlock;
    logic [7:0] r_sel, n_sel;
    logic [7:0] r_regs [NUM_REGS];

    logic       r_out_valid;
    logic [7:0] r_rdata, n_rdata;
    logic       r_handled, n_handled;
    logic       r_fwd, n_fwd;
    logic       r_re0, n_re0;
    logic       r_re1, n_re1;
    t_uart_cfg  r_u0, n_u0;
    t_uart_cfg  r_u1, n_u1;

    logic             accept;
    logic             in_cfg;
    logic             sel_ok;
    logic [IDX_W-1:0] sel_idx;
    logic [7:0]       cur_val;
    logic [7:0]       diff;
    logic             reg_wr;
    logic [7:0]       new_r1;
    logic [7:0]       new_r2;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;

    assign in_cfg  = (r_unlock == UNLOCK_IN_CFG);
    assign sel_ok  = ({1'b0, r_sel} < 9'(NUM_REGS));
    assign sel_idx = r_sel[IDX_W-1:0];
    assign cur_val = r_regs[sel_idx];
    assign diff    = i_write_data ^ cur_val;
    assign reg_wr  = accept && (i_command == CMD_WRITE) && in_cfg
                     && (i_port_offset == PORT_DATA) && sel_ok;

    // The port decode reflects the registers after this access has been applied.
    assign new_r1 = (reg_wr && r_sel == REG_COM34) ? i_write_data : r_regs[1];
    assign new_r2 = (reg_wr && r_sel == REG_UART)  ? i_write_data : r_regs[2];

    always_comb begin
        n_unlock  = r_unlock;
        n_sel     = r_sel;
        n_rdata   = 8'h00;
        n_handled = 1'b0;
        n_fwd     = 1'b0;
        n_re0     = 1'b0;
        n_re1     = 1'b0;
        if (i_command == CMD_READ) begin
            if (in_cfg && i_port_offset == PORT_DATA && sel_ok) begin
                n_rdata   = cur_val;
                n_handled = 1'b1;
            end else begin
                n_fwd = 1'b1;
            end
        end else if (in_cfg) begin
            if (i_port_offset == PORT_INDEX) begin
                if (i_write_data == LOCK_KEY) begin
                    n_unlock = 2'd0;
                end else begin
                    n_sel = i_write_data;
                end
            end else if (sel_ok) begin
                case (r_sel)
                    REG_COM34: begin
                        n_re0 = |diff[6:5];
                        n_re1 = |diff[6:5];
                    end
                    REG_UART: begin
                        n_re0 = |diff[2:0];
                        n_re1 = |diff[6:4];
                    end
                    REG_UARTAUX: begin
                        n_re0 = |diff[5:4];
                        n_re1 = |diff[5:4];
                    end
                    default: begin
                        n_re0 = 1'b0;
                        n_re1 = 1'b0;
                    end
                endcase
            end
        end else if (i_port_offset == PORT_INDEX && i_write_data == UNLOCK_KEY) begin
            // A stray count of three is not configuration mode and stays put.
            if (r_unlock < UNLOCK_IN_CFG) begin
                n_unlock = r_unlock + 2'd1;
            end
        end else begin
            n_fwd = 1'b1;
        end
        n_u0 = decode_uart(new_r2[2:0], new_r1[6:5]);
        n_u1 = decode_uart(new_r2[6:4], new_r1[6:5]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unlock    <= 2'd0;
            r_sel       <= 8'h00;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_REGS; i++) begin
                r_regs[i] <= reg_reset_value(i);
            end
        end else begin
            if (accept) begin
                r_unlock <= n_unlock;
                r_sel    <= n_sel;
            end
            if (reg_wr) begin
                r_regs[sel_idx] <= i_write_data;
            end
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rdata   <= n_rdata;
            r_handled <= n_handled;
            r_fwd     <= n_fwd;
            r_re0     <= n_re0;
            r_re1     <= n_re1;
            r_u0      <= n_u0;
            r_u1      <= n_u1;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_read_data      = r_rdata;
    assign o_read_handled   = r_handled;
    assign o_forward_access = r_fwd;
    assign o_uart0_enable   = r_u0.enable;
    assign o_uart0_base     = r_u0.base;
    assign o_uart0_irq      = r_u0.irq;
    assign o_uart0_reapply  = r_re0;
    assign o_uart1_enable   = r_u1.enable;
    assign o_uart1_base     = r_u1.base;
    assign o_uart1_irq      = r_u1.irq;
    assign o_uart1_reapply  = r_re1;

    a_handled_not_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_read_handled |-> !o_forward_access)
        else $error("handled read also flagged as forwarded");

    a_rdata_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_read_handled |-> o_read_data == 8'h00)
        else $error("read data nonzero on an unhandled access");

    a_lock_exits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && in_cfg && i_command == CMD_WRITE && i_port_offset == PORT_INDEX
        && i_write_data == LOCK_KEY |=> r_unlock == 2'd0)
        else $error("lock key did not leave configuration mode");

    a_unlock_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_unlock != 2'd3)
        else $error("unlock count reached an unreachable value");

    a_reapply_only_on_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_uart0_reapply || o_uart1_reapply)
        |-> !o_read_handled && !o_forward_access)
        else $error("reapply pulse on an access that wrote no register");

endmodule

`default_nettype wire
